@@ rtl/core/lfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared command and status types between the controller and the datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Datapath operations issued by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_TOUCH,
      OP_EVICT,
      OP_INSERT
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic found;
      logic victim_ok;
      logic free_ok;
      logic full;
   } dp_status_type;

endpackage

@@ rtl/core/lfu_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry storage and one-entry-per-cycle sweep unit. Every sweep visits all
// slots once; the operation chosen by the controller sets what each visit does.
// ----------------------------------------------------------------------------
module lfu_datapath #(
   parameter int MAX_ENTRIES = 64,
   parameter int COUNT_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lfu_pkg::dp_cmd_type   cmd,
   output lfu_pkg::dp_status_type status,
   input  logic [6:0]            capacity,
   input  logic                  in_command,
   input  logic [31:0]           in_key,
   input  logic [31:0]           in_value,
   output logic [31:0]           found_value,
   output logic [31:0]           victim_key
);
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int AW = IW + 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int RW = IW + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [31:0]            key_mem [MAX_ENTRIES];
   logic [31:0]            val_mem [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  cnt_mem [MAX_ENTRIES];
   logic [RW-1:0]          rec_mem [MAX_ENTRIES];

   logic [AW-1:0]         addr_ff;
   logic                  act_ff;
   logic [IW-1:0]         act_idx_ff;
   lfu_pkg::op_type       act_op_ff;
   logic [31:0]           rd_key_ff, rd_val_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;
   logic [RW-1:0]         rd_rec_ff;

   logic [31:0]           key_ff, val_ff;
   logic                  cmd_ff;
   logic                  found_ff, vic_ok_ff, free_ok_ff;
   logic [IW-1:0]         found_idx_ff, vic_idx_ff, free_idx_ff;
   logic [RW-1:0]         ref_rec_ff;
   logic [COUNT_BITS-1:0] vic_cnt_ff;
   logic [RW-1:0]         vic_rec_ff;
   logic [31:0]           found_val_ff, vic_key_ff;
   logic [CW-1:0]         used_ff;

   logic [CW-1:0] cap_eff;
   logic          sweep;
   logic          issue;
   logic          last;
   logic          v;

   assign cap_eff = (32'(capacity) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(capacity);
   assign sweep = (cmd.op != lfu_pkg::OP_NONE) && (cmd.op != lfu_pkg::OP_LOAD);
   assign issue = sweep && (addr_ff < AW'(MAX_ENTRIES));
   assign last  = act_ff && (act_idx_ff == IW'(MAX_ENTRIES - 1));
   assign v     = valid_ff[act_idx_ff];

   assign status.scan_last = last;
   assign status.found     = found_ff;
   assign status.victim_ok = vic_ok_ff;
   assign status.free_ok   = free_ok_ff;
   assign status.full      = (used_ff >= cap_eff) || !free_ok_ff;
   assign found_value      = found_val_ff;
   assign victim_key       = vic_key_ff;

   // Registered read of the entry at the sweep address; it is processed in the next cycle.
   always_ff @(posedge clock) begin
      act_idx_ff <= addr_ff[IW-1:0];
      act_op_ff  <= cmd.op;
      rd_key_ff  <= key_mem[addr_ff[IW-1:0]];
      rd_val_ff  <= val_mem[addr_ff[IW-1:0]];
      rd_cnt_ff  <= cnt_mem[addr_ff[IW-1:0]];
      rd_rec_ff  <= rec_mem[addr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         addr_ff  <= '0;
         act_ff   <= 1'b0;
      end else begin
         if (sweep) begin
            addr_ff <= (addr_ff == AW'(MAX_ENTRIES)) ? '0 : addr_ff + AW'(1);
         end else begin
            addr_ff <= '0;
         end
         act_ff <= issue;
         if (cmd.op == lfu_pkg::OP_LOAD) begin
            key_ff     <= in_key;
            val_ff     <= in_value;
            cmd_ff     <= in_command;
            found_ff   <= 1'b0;
            vic_ok_ff  <= 1'b0;
            free_ok_ff <= 1'b0;
            used_ff    <= '0;
         end else if (act_ff) begin
            unique case (act_op_ff)
               lfu_pkg::OP_SCAN: begin
                  if (v) begin
                     used_ff <= used_ff + CW'(1);
                     if (rd_key_ff == key_ff && !found_ff) begin
                        found_ff     <= 1'b1;
                        found_idx_ff <= act_idx_ff;
                        ref_rec_ff   <= rd_rec_ff;
                        found_val_ff <= rd_val_ff;
                     end
                     if (!vic_ok_ff || rd_cnt_ff < vic_cnt_ff ||
                         (rd_cnt_ff == vic_cnt_ff && rd_rec_ff > vic_rec_ff)) begin
                        vic_ok_ff  <= 1'b1;
                        vic_idx_ff <= act_idx_ff;
                        vic_cnt_ff <= rd_cnt_ff;
                        vic_rec_ff <= rd_rec_ff;
                        vic_key_ff <= rd_key_ff;
                     end
                  end else if (!free_ok_ff) begin
                     free_ok_ff  <= 1'b1;
                     free_idx_ff <= act_idx_ff;
                  end
               end
               lfu_pkg::OP_TOUCH: begin
                  if (act_idx_ff == found_idx_ff) begin
                     rec_mem[act_idx_ff] <= '0;
                     if (rd_cnt_ff != COUNT_MAX) begin
                        cnt_mem[act_idx_ff] <= rd_cnt_ff + COUNT_BITS'(1);
                     end
                     if (cmd_ff == lfu_pkg::CMD_PUT) begin
                        val_mem[act_idx_ff] <= val_ff;
                     end
                  end else if (v && rd_rec_ff < ref_rec_ff) begin
                     rec_mem[act_idx_ff] <= rd_rec_ff + RW'(1);
                  end
               end
               lfu_pkg::OP_EVICT: begin
                  // Victim leaves; older ranks close the gap. Its slot is the new free slot.
                  if (act_idx_ff == vic_idx_ff) begin
                     valid_ff[act_idx_ff] <= 1'b0;
                     free_ok_ff           <= 1'b1;
                     free_idx_ff          <= act_idx_ff;
                  end else if (v && rd_rec_ff > vic_rec_ff) begin
                     rec_mem[act_idx_ff] <= rd_rec_ff - RW'(1);
                  end
               end
               lfu_pkg::OP_INSERT: begin
                  if (act_idx_ff == free_idx_ff) begin
                     valid_ff[act_idx_ff] <= 1'b1;
                     key_mem[act_idx_ff]  <= key_ff;
                     val_mem[act_idx_ff]  <= val_ff;
                     cnt_mem[act_idx_ff]  <= COUNT_BITS'(1);
                     rec_mem[act_idx_ff]  <= '0;
                  end else if (v) begin
                     rec_mem[act_idx_ff] <= rd_rec_ff + RW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

@@ rtl/core/lfu_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences the sweeps for one item and holds the result register.
// ----------------------------------------------------------------------------
module lfu_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [6:0]             capacity,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic [31:0]            rsp_read_value,
   output logic                   rsp_evicted,
   output logic [31:0]            rsp_evicted_key,
   output lfu_pkg::dp_cmd_type    cmd,
   input  lfu_pkg::dp_status_type status,
   input  logic [31:0]            found_value,
   input  logic [31:0]            victim_key
);
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_TOUCH, S_EVICT, S_INSERT, S_DONE
   } state_type;

   state_type   state_ff;
   logic        cmd_ff;
   logic        hit_ff;
   logic [31:0] read_value_ff;
   logic        evicted_ff;
   logic [31:0] evicted_key_ff;
   logic        out_busy;
   logic        accept;

   assign out_busy  = rsp_valid && rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      unique case (state_ff)
         S_IDLE:   cmd.op = accept ? lfu_pkg::OP_LOAD : lfu_pkg::OP_NONE;
         S_SCAN:   cmd.op = lfu_pkg::OP_SCAN;
         S_TOUCH:  cmd.op = lfu_pkg::OP_TOUCH;
         S_EVICT:  cmd.op = lfu_pkg::OP_EVICT;
         S_INSERT: cmd.op = lfu_pkg::OP_INSERT;
         default:  cmd.op = lfu_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         if (state_ff == S_DONE && !out_busy) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff   <= req_command;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (status.scan_last) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               // The earlier result may still be held on the outputs, so the
               // new one is staged until it is taken.
               hit_ff         <= status.found;
               read_value_ff  <= '1;
               evicted_ff     <= 1'b0;
               evicted_key_ff <= '0;
               if (cmd_ff == lfu_pkg::CMD_GET) begin
                  if (status.found) begin
                     read_value_ff <= found_value;
                     state_ff      <= S_TOUCH;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else if (capacity == '0) begin
                  state_ff <= S_DONE;
               end else if (status.found) begin
                  state_ff <= S_TOUCH;
               end else if (status.full && status.victim_ok) begin
                  evicted_ff     <= 1'b1;
                  evicted_key_ff <= victim_key;
                  state_ff       <= S_EVICT;
               end else if (status.free_ok) begin
                  state_ff <= S_INSERT;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_TOUCH, S_INSERT: begin
               if (status.scan_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_EVICT: begin
               if (status.scan_last) begin
                  state_ff <= S_INSERT;
               end
            end
            S_DONE: begin
               if (!out_busy) begin
                  rsp_hit         <= hit_ff;
                  rsp_read_value  <= read_value_ff;
                  rsp_evicted     <= evicted_ff;
                  rsp_evicted_key <= evicted_key_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/core/lfu_key_value_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU key-value cache
// Fully associative store with least-frequently-used replacement.
//
//   channel   dir   handshake          payload
//   req_      in    valid / stall      command, key, value
//   rsp_      out   valid / stall      hit, read_value, evicted, evicted_key
//   csr_      in    write enable       capacity
//
// Every item starts with a scan sweep; a miss get ends there, a hit or an insert into a
// free slot adds a touch or insert sweep, and an eviction runs an evict sweep before it.
// Each sweep reads the entries through a registered memory read and moves one entry
// per cycle through the single datapath scan unit.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled result is held while the block finishes the next item's sweeps;
// that item then waits until the held result is taken.
// ----------------------------------------------------------------------------
module lfu_key_value_cache #(
   parameter int MAX_ENTRIES = 64,
   parameter int COUNT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [31:0] rsp_read_value,
   output logic        rsp_evicted,
   output logic [31:0] rsp_evicted_key
);
   logic [6:0]             capacity_ff;
   lfu_pkg::dp_cmd_type    cmd;
   lfu_pkg::dp_status_type status;
   logic [31:0]            found_value, victim_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 7'd64;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   lfu_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_command,
      .capacity(capacity_ff), .rsp_valid, .rsp_stall, .rsp_hit, .rsp_read_value,
      .rsp_evicted, .rsp_evicted_key, .cmd, .status, .found_value, .victim_key
   );

   lfu_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_datapath (
      .clock, .reset, .cmd, .status, .capacity(capacity_ff),
      .in_command(req_command), .in_key(req_key), .in_value(req_value),
      .found_value, .victim_key
   );

endmodule

@@ rtl/core/lfu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache port checker
// Port-level properties of the cache's handshakes and results.
// ----------------------------------------------------------------------------
module lfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic [31:0] rsp_read_value,
   input logic        rsp_evicted,
   input logic [31:0] rsp_evicted_key
);
   // An item is taken only while no earlier item is in work.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while busy");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value))
      else $error("stalled result changed");

   a_evict_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit && rsp_read_value == '1)
      else $error("eviction reported with a hit");

   a_no_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_key == '0)
      else $error("evicted key without eviction");

endmodule

bind lfu_key_value_cache lfu_checker u_lfu_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_hit,
   .rsp_read_value, .rsp_evicted, .rsp_evicted_key
);

@@ verif/tb_lfu_key_value_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU key-value cache testbench
// Drives get and put items through the request channel, predicts every
// response with a behavioral copy of the store (use counts, recency ranks,
// LFU eviction with oldest-first ties) and compares each field. Capacity is
// changed between phases while the cache is idle, and both channels idle
// and stall at random in several mixes.
// ----------------------------------------------------------------------------
module tb_lfu_key_value_cache;

   localparam int NUM_SLOTS  = 64;
   localparam int COUNT_TOP  = 65535;
   localparam int DRAIN_WAIT = 3 * NUM_SLOTS + 10;
   localparam int PEND_DEPTH = 16;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } lookup_result_type;

   typedef struct {
      logic        command;
      logic [31:0] key;
      logic [31:0] value;
      logic        known;
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [6:0]  csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [31:0] req_key;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_hit;
   logic [31:0] rsp_read_value;
   logic        rsp_evicted;
   logic [31:0] rsp_evicted_key;

   // Shadow copy of the cache contents.
   logic        shadow_valid [NUM_SLOTS];
   logic [31:0] shadow_key   [NUM_SLOTS];
   logic [31:0] shadow_value [NUM_SLOTS];
   int unsigned shadow_count [NUM_SLOTS];
   int unsigned shadow_rank  [NUM_SLOTS];
   int unsigned shadow_capacity;

   // Expected responses in order, as a ring indexed by the two counts.
   lookup_result_type pending_results [PEND_DEPTH];
   logic              pending_known   [PEND_DEPTH];
   lookup_result_type pending_fixed   [PEND_DEPTH];
   int  sent_count;
   int  checked_count;
   int  mismatch_count;
   int  sender_idle_pct;
   int  receiver_stall_pct;
   longint cycle_count;
   logic [31:0] key_pool [16];

   lfu_key_value_cache dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value), .rsp_evicted(rsp_evicted),
      .rsp_evicted_key(rsp_evicted_key)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("lfu_key_value_cache: mismatch");
            $finish;
         end
      end
   end

   function automatic int find_slot(logic [31:0] k);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_valid[i] && shadow_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void promote_slot(int s);
      int unsigned r;
      r = shadow_rank[s];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_valid[i] && i != s && shadow_rank[i] < r) shadow_rank[i]++;
      shadow_rank[s] = 0;
      if (shadow_count[s] < COUNT_TOP) shadow_count[s]++;
   endfunction

   function automatic lookup_result_type apply_lookup(logic cmd, logic [31:0] k,
                                                      logic [31:0] v);
      lookup_result_type res;
      int s;
      int slot;
      int victim;
      int unsigned used;
      int unsigned cap;
      int unsigned r;
      cap = (shadow_capacity > NUM_SLOTS) ? NUM_SLOTS : shadow_capacity;
      s = find_slot(k);
      res.hit = (s >= 0);
      res.read_value = '1;
      res.evicted = 1'b0;
      res.evicted_key = '0;
      if (cmd == lfu_pkg::CMD_GET) begin
         if (s >= 0) begin
            promote_slot(s);
            res.read_value = shadow_value[s];
         end
      end else if (cap != 0) begin
         if (s >= 0) begin
            shadow_value[s] = v;
            promote_slot(s);
         end else begin
            used = 0;
            slot = -1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (shadow_valid[i]) used++;
               else if (slot < 0) slot = i;
            end
            if (used >= cap || slot < 0) begin
               victim = -1;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (!shadow_valid[i]) continue;
                  if (victim < 0 || shadow_count[i] < shadow_count[victim] ||
                      (shadow_count[i] == shadow_count[victim] &&
                       shadow_rank[i] > shadow_rank[victim]))
                     victim = i;
               end
               if (victim >= 0) begin
                  r = shadow_rank[victim];
                  res.evicted = 1'b1;
                  res.evicted_key = shadow_key[victim];
                  shadow_valid[victim] = 1'b0;
                  for (int i = 0; i < NUM_SLOTS; i++)
                     if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
                  slot = victim;
               end
            end
            if (slot >= 0) begin
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (shadow_valid[i]) shadow_rank[i]++;
               shadow_valid[slot] = 1'b1;
               shadow_key[slot] = k;
               shadow_value[slot] = v;
               shadow_count[slot] = 1;
               shadow_rank[slot] = 0;
            end
         end
      end
      return res;
   endfunction

   // Response checker: outputs are sampled at the rising edge.
   initial begin
      lookup_result_type want;
      lookup_result_type fixed;
      logic              known;
      mismatch_count = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (checked_count == sent_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response item: hit=%0b read=%h", rsp_hit,
                           rsp_read_value);
            end else begin
               want = pending_results[checked_count % PEND_DEPTH];
               known = pending_known[checked_count % PEND_DEPTH];
               fixed = pending_fixed[checked_count % PEND_DEPTH];
               checked_count++;
               if (rsp_hit !== want.hit || rsp_read_value !== want.read_value ||
                   rsp_evicted !== want.evicted ||
                   rsp_evicted_key !== want.evicted_key ||
                   (known && (fixed.hit !== want.hit ||
                              fixed.read_value !== want.read_value ||
                              fixed.evicted !== want.evicted ||
                              fixed.evicted_key !== want.evicted_key))) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("response mismatch: exp hit=%0b rd=%h ev=%0b evk=%h",
                              want.hit, want.read_value, want.evicted,
                              want.evicted_key,
                              " got hit=%0b rd=%h ev=%0b evk=%h", rsp_hit,
                              rsp_read_value, rsp_evicted, rsp_evicted_key);
               end
            end
         end
      end
   end

   // The receiver stalls at random per the current mix.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic send_item(logic cmd, logic [31:0] k, logic [31:0] v,
                            logic known, lookup_result_type fixed);
      lookup_result_type want;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_key <= k;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      want = apply_lookup(cmd, k, v);
      pending_results[sent_count % PEND_DEPTH] = want;
      pending_known[sent_count % PEND_DEPTH] = known;
      pending_fixed[sent_count % PEND_DEPTH] = fixed;
      sent_count++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_and_wait();
      while (sent_count != checked_count) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_capacity(int unsigned cap);
      drain_and_wait();
      csr_write_enable <= 1'b1;
      csr_write_data <= cap[6:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity = cap;
   endtask

   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(9);
      if (sel < 8) return key_pool[$urandom_range(15)];
      return $urandom;
   endfunction

   task automatic random_phase(int items, int idle_pct, int stall_pct);
      lookup_result_type none;
      none = '{default: '0};
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < items; n++) begin
         // Runs of no idling fall inside every mix.
         if ($urandom_range(9) == 0) sender_idle_pct = 0;
         else if ($urandom_range(9) == 0) sender_idle_pct = idle_pct;
         send_item(1'($urandom_range(1)), pick_key(), $urandom, 1'b0, none);
      end
   endtask

   directed_row_type directed_rows[$];

   initial begin
      lookup_result_type fixed;
      directed_row_type  row;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_command = lfu_pkg::CMD_GET;
      req_key = '0;
      req_value = '0;
      sent_count = 0;
      checked_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      shadow_capacity = 64;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i] = '0;
         shadow_value[i] = '0;
         shadow_count[i] = 0;
         shadow_rank[i] = 0;
      end
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: fixed responses where they are obvious.
      directed_rows = '{
         '{lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0, 1, 0, 32'hFFFF_FFFF, 0, 32'h0},
         '{lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 32'hFFFF_FFFF, 0, 32'h0},
         '{lfu_pkg::CMD_GET, 32'h8000_0000, 32'h0, 1, 1, 32'h7FFF_FFFF, 0, 32'h0},
         '{lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 32'hFFFF_FFFF, 0, 32'h0},
         '{lfu_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'h8000_0000, 0, 32'h0},
         '{lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, 0, 32'h0},
         '{lfu_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0, 1, 1, 32'h0000_0000, 0, 32'h0},
         '{lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
         '{lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 0, 0},
         '{lfu_pkg::CMD_GET, 32'h1234_5678, 32'h0, 1, 0, 32'hFFFF_FFFF, 0, 32'h0}
      };
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         fixed = '{row.hit, row.read_value, row.evicted, row.evicted_key};
         send_item(row.command, row.key, row.value, row.known, fixed);
      end

      // Capacity 2: eviction of the least used entry, ties to the oldest.
      fixed = '{default: '0};
      write_capacity(2);
      send_item(lfu_pkg::CMD_PUT, 32'h0000_0010, 32'h1, 0, fixed);
      send_item(lfu_pkg::CMD_PUT, 32'h0000_0020, 32'h2, 0, fixed);
      send_item(lfu_pkg::CMD_GET, 32'h0000_0020, 32'h0, 0, fixed);
      send_item(lfu_pkg::CMD_PUT, 32'h0000_0030, 32'h3, 0, fixed);
      // Capacity zero: puts change nothing, gets still work.
      write_capacity(0);
      send_item(lfu_pkg::CMD_PUT, 32'h0000_0040, 32'h4, 0, fixed);
      send_item(lfu_pkg::CMD_PUT, 32'h0000_0030, 32'h5, 0, fixed);
      send_item(lfu_pkg::CMD_GET, 32'h0000_0030, 32'h0, 0, fixed);
      // Above the slot count is treated as the slot count.
      write_capacity(127);
      send_item(lfu_pkg::CMD_PUT, 32'h0000_0050, 32'h6, 0, fixed);

      // Random phases with several capacities and idling mixes.
      write_capacity(8);
      random_phase(300, 0, 0);
      write_capacity(3);
      random_phase(300, 65, 0);
      // Below the held count, every put of a new key evicts one entry; the count does not shrink.
      write_capacity(1);
      random_phase(250, 0, 65);
      write_capacity(64);
      random_phase(300, 30, 30);
      write_capacity(0);
      random_phase(100, 0, 0);
      write_capacity(127);
      random_phase(200, 30, 30);
      write_capacity(12);
      random_phase(180, 0, 0);
      // Sender waits for every response before resuming.
      while (sent_count != checked_count) @(negedge clock);
      write_capacity(5);
      random_phase(300, 65, 65);

      drain_and_wait();
      if (mismatch_count == 0) begin
         $display("lfu_key_value_cache: match");
      end else begin
         $display("lfu_key_value_cache: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/lfu_pkg.sv
rtl/core/lfu_datapath.sv
rtl/core/lfu_control.sv
rtl/core/lfu_key_value_cache.sv
rtl/core/lfu_checker.sv
verif/tb_lfu_key_value_cache.sv
